// ----- sv/rfa_pkg.sv -----
// Package for the rational fraction ALU: opcodes, widths and the command class type.
// Used by rfa_front, rfa_back and rational_fraction_alu. No dependencies.
package rfa_pkg;

	localparam int OperandWidth = 16;
	localparam int ResultWidth  = 33;
	localparam int OpcodeWidth  = 3;

	typedef enum logic [OpcodeWidth-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INV = 3'd4
	} opcode_t;

	// classification made by the front end
	typedef enum logic [2:0] {
		CLS_ADDSUB,
		CLS_MUL,
		CLS_DIV,
		CLS_INV,
		CLS_BAD,
		CLS_NONE
	} op_class_t;

endpackage

// ----- sv/rational_fraction_alu.sv -----
// Rational fraction ALU, top level: front end, command queue, back end, output register.
// Depends on rfa_pkg, rfa_front and rfa_back.
// From acceptance to out_valid: inverse, bad input and unused opcodes are answered from
// the idle state; multiply and divide pass through the product state; add and subtract
// run the Euclid remainders, d1/g and d2/g on the divider, then the scale and LCM states,
// plus any time spent waiting in the queue. The back end takes one transaction at a time,
// and the next in the cycle after its result is accepted; the two-entry queue takes input while not full.
// Reset (arst_n low) empties the queue and drops out_valid at once.
module rational_fraction_alu #(
	parameter int OPERAND_WIDTH = rfa_pkg::OperandWidth
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rfa_pkg::OpcodeWidth-1:0]        opcode,
	input  logic signed [OPERAND_WIDTH-1:0]       first_numerator,
	input  logic signed [OPERAND_WIDTH-1:0]       first_denominator,
	input  logic signed [OPERAND_WIDTH-1:0]       second_numerator,
	input  logic signed [OPERAND_WIDTH-1:0]       second_denominator,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rfa_pkg::ResultWidth-1:0] result_numerator,
	output logic signed [rfa_pkg::ResultWidth-1:0] result_denominator,
	output logic                                  bad_denominator
);

	logic                            cmd_valid, cmd_ready, cmd_sub;
	rfa_pkg::op_class_t              cmd_cls;
	logic signed [OPERAND_WIDTH-1:0] cmd_n1, cmd_d1, cmd_n2, cmd_d2;
	logic [rfa_pkg::ResultWidth-1:0] res_num, res_den;

	rfa_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk, .arst_n,
		.valid(in_valid), .ready(in_ready), .opcode,
		.first_numerator, .first_denominator, .second_numerator, .second_denominator,
		.cmd_valid, .cmd_ready, .cmd_cls, .cmd_sub,
		.cmd_n1, .cmd_d1, .cmd_n2, .cmd_d2
	);

	rfa_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
		.clk, .arst_n,
		.cmd_valid, .cmd_ready, .cmd_cls, .cmd_sub,
		.cmd_n1, .cmd_d1, .cmd_n2, .cmd_d2,
		.res_valid(out_valid), .res_ready(out_ready),
		.res_num, .res_den, .res_bad(bad_denominator)
	);

	assign result_numerator   = res_num;
	assign result_denominator = res_den;

	// a flagged result carries zero parts
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_denominator |-> result_numerator == '0 && result_denominator == '0)
		else $error("bad_denominator with nonzero result");

	// the back end takes no command while a result waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cmd_ready)
		else $error("command taken while result pending");

	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_numerator)
			&& $stable(result_denominator) && $stable(bad_denominator))
		else $error("result changed while waiting");

endmodule

// ----- sv/rfa_front.sv -----
// Front end: accepts transactions, classifies the opcode and pushes a command
// into a two-entry queue toward the back end. Depends on rfa_pkg.
module rfa_front #(
	parameter int OPERAND_WIDTH = rfa_pkg::OperandWidth
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 ready,
	input  logic [rfa_pkg::OpcodeWidth-1:0]       opcode,
	input  logic signed [OPERAND_WIDTH-1:0]      first_numerator,
	input  logic signed [OPERAND_WIDTH-1:0]      first_denominator,
	input  logic signed [OPERAND_WIDTH-1:0]      second_numerator,
	input  logic signed [OPERAND_WIDTH-1:0]      second_denominator,
	output logic                                 cmd_valid,
	input  logic                                 cmd_ready,
	output rfa_pkg::op_class_t                   cmd_cls,
	output logic                                 cmd_sub,
	output logic signed [OPERAND_WIDTH-1:0]      cmd_n1,
	output logic signed [OPERAND_WIDTH-1:0]      cmd_d1,
	output logic signed [OPERAND_WIDTH-1:0]      cmd_n2,
	output logic signed [OPERAND_WIDTH-1:0]      cmd_d2
);

	localparam int Depth = 2;

	typedef struct packed {
		rfa_pkg::op_class_t cls;
		logic               sub;
		logic [OPERAND_WIDTH-1:0] n1;
		logic [OPERAND_WIDTH-1:0] d1;
		logic [OPERAND_WIDTH-1:0] n2;
		logic [OPERAND_WIDTH-1:0] d2;
	} cmd_t;

	cmd_t       entry_q [Depth];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       new_cmd;
	logic       push, pop;

	// classify
	always_comb begin
		new_cmd.sub = (opcode == rfa_pkg::OP_SUB);
		new_cmd.n1  = first_numerator;
		new_cmd.d1  = first_denominator;
		new_cmd.n2  = second_numerator;
		new_cmd.d2  = second_denominator;
		unique case (opcode)
			rfa_pkg::OP_ADD, rfa_pkg::OP_SUB: begin
				if (first_denominator <= 0 || second_denominator <= 0)
					new_cmd.cls = rfa_pkg::CLS_BAD;
				else
					new_cmd.cls = rfa_pkg::CLS_ADDSUB;
			end
			rfa_pkg::OP_MUL: new_cmd.cls = rfa_pkg::CLS_MUL;
			rfa_pkg::OP_DIV: new_cmd.cls = rfa_pkg::CLS_DIV;
			rfa_pkg::OP_INV: new_cmd.cls = rfa_pkg::CLS_INV;
			default:         new_cmd.cls = rfa_pkg::CLS_NONE;
		endcase
	end

	assign ready     = (count_q != 2'(Depth));
	assign push      = valid && ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;

	assign cmd_cls = entry_q[rd_ptr_q].cls;
	assign cmd_sub = entry_q[rd_ptr_q].sub;
	assign cmd_n1  = entry_q[rd_ptr_q].n1;
	assign cmd_d1  = entry_q[rd_ptr_q].d1;
	assign cmd_n2  = entry_q[rd_ptr_q].n2;
	assign cmd_d2  = entry_q[rd_ptr_q].d2;

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= new_cmd;
	end

endmodule

// ----- sv/rfa_back.sv -----
// Back end: sequencer for one command at a time. Euclid and the quotients d/g by a
// radix-2 restoring divider, products by two registered multiplies. Depends on rfa_pkg.
module rfa_back #(
	parameter int OPERAND_WIDTH = rfa_pkg::OperandWidth
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_valid,
	output logic                                   cmd_ready,
	input  rfa_pkg::op_class_t                     cmd_cls,
	input  logic                                   cmd_sub,
	input  logic signed [OPERAND_WIDTH-1:0]        cmd_n1,
	input  logic signed [OPERAND_WIDTH-1:0]        cmd_d1,
	input  logic signed [OPERAND_WIDTH-1:0]        cmd_n2,
	input  logic signed [OPERAND_WIDTH-1:0]        cmd_d2,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic [rfa_pkg::ResultWidth-1:0]        res_num,
	output logic [rfa_pkg::ResultWidth-1:0]        res_den,
	output logic                                   res_bad
);

	localparam int W   = OPERAND_WIDTH;
	localparam int RW  = rfa_pkg::ResultWidth;
	localparam int CW  = $clog2(W + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_PROD, S_SCALE, S_LCM
	} state_t;

	// what the divider is working on
	typedef enum logic [1:0] {
		PH_GCD, PH_Q1, PH_Q2
	} div_phase_t;

	state_t                state_q;
	div_phase_t            phase_q;
	logic                  sub_q;
	logic signed [W-1:0]   n1_q, n2_q;
	logic [W-1:0]          d1_q, d2_q;
	logic [W-1:0]          quo_q, rem_q, dvs_q;   // divider: dividend/quotient, remainder, divisor
	logic [W-1:0]          q1_q;                  // d1/g
	logic [CW-1:0]         cnt_q;
	logic signed [W-1:0]   x1_q, y1_q, x2_q, y2_q; // multiplier operands
	logic [RW-1:0]         s1_q, s2_q;
	logic [RW-1:0]         num_q, den_q;
	logic                  bad_q;
	logic [W:0]            shifted, trial;
	logic [W-1:0]          rem_next, quo_next;
	logic signed [2*W-1:0] prod_a, prod_b;

	assign cmd_ready = (state_q == S_IDLE) && !res_valid;
	assign res_num   = num_q;
	assign res_den   = den_q;
	assign res_bad   = bad_q;

	// one restoring division step: rem_q:quo_q / dvs_q
	assign shifted  = {rem_q, quo_q[W-1]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign rem_next = trial[W] ? shifted[W-1:0] : trial[W-1:0];
	assign quo_next = {quo_q[W-2:0], ~trial[W]};

	// shared multipliers
	assign prod_a = (2*W)'(x1_q) * (2*W)'(y1_q);
	assign prod_b = (2*W)'(x2_q) * (2*W)'(y2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_GCD;
			res_valid <= 1'b0;
			sub_q     <= 1'b0;
			n1_q      <= '0;
			n2_q      <= '0;
			d1_q      <= '0;
			d2_q      <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			dvs_q     <= '0;
			q1_q      <= '0;
			cnt_q     <= '0;
			x1_q      <= '0;
			y1_q      <= '0;
			x2_q      <= '0;
			y2_q      <= '0;
			s1_q      <= '0;
			s2_q      <= '0;
			num_q     <= '0;
			den_q     <= '0;
			bad_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (res_valid) begin
						if (res_ready) res_valid <= 1'b0;
					end else if (cmd_valid) begin
						sub_q <= cmd_sub;
						n1_q  <= cmd_n1;
						n2_q  <= cmd_n2;
						d1_q  <= cmd_d1;
						d2_q  <= cmd_d2;
						unique case (cmd_cls)
							rfa_pkg::CLS_ADDSUB: begin
								bad_q   <= 1'b0;
								quo_q   <= cmd_d1;
								rem_q   <= '0;
								dvs_q   <= cmd_d2;
								cnt_q   <= CW'(W);
								phase_q <= PH_GCD;
								state_q <= S_DIV;
							end
							rfa_pkg::CLS_MUL: begin
								bad_q   <= 1'b0;
								x1_q    <= cmd_n1;
								y1_q    <= cmd_n2;
								x2_q    <= cmd_d1;
								y2_q    <= cmd_d2;
								state_q <= S_PROD;
							end
							rfa_pkg::CLS_DIV: begin
								bad_q   <= 1'b0;
								x1_q    <= cmd_n1;
								y1_q    <= cmd_d2;
								x2_q    <= cmd_d1;
								y2_q    <= cmd_n2;
								state_q <= S_PROD;
							end
							rfa_pkg::CLS_INV: begin
								bad_q     <= 1'b0;
								num_q     <= RW'(cmd_d1);
								den_q     <= RW'(cmd_n1);
								res_valid <= 1'b1;
							end
							rfa_pkg::CLS_BAD: begin
								bad_q     <= 1'b1;
								num_q     <= '0;
								den_q     <= '0;
								res_valid <= 1'b1;
							end
							default: begin
								bad_q     <= 1'b0;
								num_q     <= '0;
								den_q     <= '0;
								res_valid <= 1'b1;
							end
						endcase
					end
				end
				// bit-serial division, used for Euclid remainders, d1/g and d2/g
				S_DIV: begin
					if (cnt_q != CW'(1)) begin
						rem_q <= rem_next;
						quo_q <= quo_next;
						cnt_q <= cnt_q - CW'(1);
					end else begin
						unique case (phase_q)
							PH_GCD: begin
								if (rem_next == '0) begin
									// dvs_q is the gcd: divide d1 by it
									quo_q   <= d1_q;
									rem_q   <= '0;
									cnt_q   <= CW'(W);
									phase_q <= PH_Q1;
								end else begin
									quo_q <= dvs_q;
									dvs_q <= rem_next;
									rem_q <= '0;
									cnt_q <= CW'(W);
								end
							end
							PH_Q1: begin
								q1_q    <= quo_next;
								quo_q   <= d2_q;
								rem_q   <= '0;
								cnt_q   <= CW'(W);
								phase_q <= PH_Q2;
							end
							PH_Q2: begin
								// scale factors: L/d1 = d2/g, L/d2 = d1/g
								x1_q    <= n1_q;
								y1_q    <= signed'(quo_next);
								x2_q    <= n2_q;
								y2_q    <= signed'(q1_q);
								state_q <= S_SCALE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// multiply and divide products
				S_PROD: begin
					num_q     <= RW'(prod_a);
					den_q     <= RW'(prod_b);
					res_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				// scaled numerators, then L = (d1/g) * d2
				S_SCALE: begin
					s1_q    <= RW'(prod_a);
					s2_q    <= RW'(prod_b);
					x1_q    <= signed'(q1_q);
					y1_q    <= signed'(d2_q);
					state_q <= S_LCM;
				end
				S_LCM: begin
					num_q     <= sub_q ? s1_q - s2_q : s1_q + s2_q;
					den_q     <= RW'(prod_a);
					res_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Testbench for rational_fraction_alu: directed and random fraction transactions
// checked against a local predictor. Depends on rfa_pkg and the RTL top level.
`timescale 1ns / 100ps

module testbench;

	localparam int W         = rfa_pkg::OperandWidth;
	localparam int RW        = rfa_pkg::ResultWidth;
	localparam int OW        = rfa_pkg::OpcodeWidth;
	localparam int IdleLimit = 20000;

	typedef struct {
		logic signed [RW-1:0] num;
		logic signed [RW-1:0] den;
		logic                 bad;
	} frac_res_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [OW-1:0] opcode;
	logic signed [W-1:0] first_numerator, first_denominator;
	logic signed [W-1:0] second_numerator, second_denominator;
	logic signed [RW-1:0] result_numerator, result_denominator;
	logic bad_denominator;

	frac_res_t expected_q[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  hold_off    = 0;
	bit  draining    = 0;

	rational_fraction_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode),
		.first_numerator(first_numerator), .first_denominator(first_denominator),
		.second_numerator(second_numerator), .second_denominator(second_denominator),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_numerator(result_numerator), .result_denominator(result_denominator),
		.bad_denominator(bad_denominator)
	);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Euclid on positive values
	function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// expected fraction for one transaction, wrapped to the result width
	function automatic frac_res_t predict_fraction(logic [OW-1:0] op,
			logic signed [W-1:0] n1, logic signed [W-1:0] d1,
			logic signed [W-1:0] n2, logic signed [W-1:0] d2);
		frac_res_t r;
		longint sn1, sd1, sn2, sd2, lcm, rn, rd;
		sn1 = n1; sd1 = d1; sn2 = n2; sd2 = d2;
		rn = 0; rd = 0;
		r.bad = 0;
		case (op)
			rfa_pkg::OP_ADD, rfa_pkg::OP_SUB: begin
				if (sd1 <= 0 || sd2 <= 0) begin
					r.bad = 1;
				end else begin
					lcm = (sd1 / longint'(gcd_of(unsigned'(sd1), unsigned'(sd2)))) * sd2;
					rn = (op == rfa_pkg::OP_ADD) ? sn1 * (lcm / sd1) + sn2 * (lcm / sd2)
					                             : sn1 * (lcm / sd1) - sn2 * (lcm / sd2);
					rd = lcm;
				end
			end
			rfa_pkg::OP_MUL: begin
				rn = sn1 * sn2;
				rd = sd1 * sd2;
			end
			rfa_pkg::OP_DIV: begin
				rn = sn1 * sd2;
				rd = sd1 * sn2;
			end
			rfa_pkg::OP_INV: begin
				rn = sd1;
				rd = sn1;
			end
			default: ;
		endcase
		r.num = rn[RW-1:0];
		r.den = rd[RW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	// send one transaction after a random gap (none with no_gap); called and left at a falling edge
	task automatic send_fraction(logic [OW-1:0] op, logic signed [W-1:0] n1,
			logic signed [W-1:0] d1, logic signed [W-1:0] n2, logic signed [W-1:0] d2,
			bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 5);
		repeat (gap) @(negedge clk);
		in_valid           = 1;
		opcode             = op;
		first_numerator    = n1;
		first_denominator  = d1;
		second_numerator   = n2;
		second_denominator = d2;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(predict_fraction(op, n1, d1, n2, d2));
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic logic signed [W-1:0] rand_val();
		case ($urandom_range(0, 5))
			0: return W'($urandom_range(1, 12));
			1: return -W'($urandom_range(0, 12));
			2: return 16'sh7fff - W'($urandom_range(0, 3));
			3: return 16'sh8000 + W'($urandom_range(0, 3));
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic signed [W-1:0] rand_pos_den();
		case ($urandom_range(0, 3))
			0: return W'($urandom_range(1, 60));
			1: return 16'sh7fff - W'($urandom_range(0, 100));
			default: return W'($urandom_range(1, 32767));
		endcase
	endfunction

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random wait before each result (none while draining), optionally held off
	initial begin
		int wait_cycles;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
			end else begin
				wait_cycles = draining ? 0 : $urandom_range(0, 5);
				if (wait_cycles != 0) begin
					out_ready <= 0;
					repeat (wait_cycles) @(negedge clk);
				end
				out_ready <= 1;
				@(posedge clk);
				while (!(out_valid && out_ready) && !hold_off) @(posedge clk);
			end
		end
	end

	// result checker
	initial begin
		frac_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", result_numerator, 0);
				end else begin
					want = expected_q.pop_front();
					if (result_numerator !== want.num)
						report_mismatch("numerator", result_numerator, want.num);
					if (result_denominator !== want.den)
						report_mismatch("denominator", result_denominator, want.den);
					if (bad_denominator !== want.bad)
						report_mismatch("bad_denominator", bad_denominator, want.bad);
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_fraction(rfa_pkg::OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
		send_fraction(rfa_pkg::OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
		send_fraction(rfa_pkg::OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe);
		send_fraction(rfa_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7ffe);
		send_fraction(rfa_pkg::OP_ADD, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
		send_fraction(rfa_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd1);
		send_fraction(rfa_pkg::OP_ADD, 16'sd5, 16'sd0, 16'sd1, 16'sd3);
		send_fraction(rfa_pkg::OP_SUB, 16'sd5, 16'sd3, 16'sd1, -16'sd3);
		send_fraction(rfa_pkg::OP_ADD, 16'sd5, 16'sh8000, 16'sd1, 16'sd0);
		send_fraction(rfa_pkg::OP_ADD, -16'sd1, 16'sd6, -16'sd1, 16'sd6);
		send_fraction(rfa_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_fraction(rfa_pkg::OP_MUL, 16'sh7fff, 16'sd0, -16'sd1, -16'sd5);
		send_fraction(rfa_pkg::OP_DIV, 16'sh8000, 16'sh7fff, 16'sd0, 16'sh8000);
		send_fraction(rfa_pkg::OP_DIV, -16'sd3, -16'sd4, 16'sh7fff, 16'sd2);
		send_fraction(rfa_pkg::OP_INV, 16'sh8000, 16'sh7fff, 16'sd1, 16'sd1);
		send_fraction(rfa_pkg::OP_INV, 16'sd0, -16'sd1, 16'sh8000, 16'sd0);
		send_fraction(3'd5, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
		send_fraction(3'd6, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
		send_fraction(3'd7, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
	endtask

	task automatic test_random(int count);
		logic [OW-1:0] op;
		logic signed [W-1:0] d1, d2;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 9) < 5) ? OW'($urandom_range(0, 1))
			                                : OW'($urandom_range(0, 7));
			if ((op == rfa_pkg::OP_ADD || op == rfa_pkg::OP_SUB) && $urandom_range(0, 7) != 0)
			begin
				d1 = rand_pos_den();
				d2 = rand_pos_den();
			end else begin
				d1 = rand_val();
				d2 = rand_val();
			end
			send_fraction(op, rand_val(), d1, rand_val(), d2);
		end
	endtask

	// receiver holds off while items keep coming, then sender waits for drain
	task automatic test_backpressure();
		@(negedge clk);
		hold_off = 1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 12; i++)
				send_fraction(OW'($urandom_range(0, 4)), rand_val(),
					W'($urandom_range(1, 40)), rand_val(), W'($urandom_range(1, 40)), 1);
		join
		wait_drained();
		test_random(10);
	endtask

	initial begin
		arst_n             = 0;
		in_valid           = 0;
		opcode             = '0;
		first_numerator    = '0;
		first_denominator  = '0;
		second_numerator   = '0;
		second_denominator = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		wait_drained();
		test_random(1080);

		draining = 1;
		wait_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/rfa_pkg.sv
sv/rfa_front.sv
sv/rfa_back.sv
sv/rational_fraction_alu.sv
tb/testbench.sv
